/* rtl/linear_adhsr_envelope_defines.svh */
// assertion macros for the adhsr envelope checker
`ifndef LINEAR_ADHSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADHSR_ENVELOPE_DEFINES_SVH

// same-cycle implication
`define ADHSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adhsr port check failed");

// next-cycle implication
`define ADHSR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adhsr port check failed");

`endif

/* rtl/adhsr_pkg.sv */
// shared types and constants for the adhsr envelope
`default_nettype none
package adhsr_pkg;

    localparam int LVL_W  = 16;
    localparam int QUOT_W = 16;
    localparam int FACT_W = 17;

    localparam logic [LVL_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    localparam logic [1:0] END_STOP    = 2'd0;
    localparam logic [1:0] END_RESTART = 2'd1;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_HOLD    = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_SUSTAIN = 3'd4;
    localparam logic [2:0] REG_ENDMODE = 3'd5;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_HOLD    = 3'd2,
        PH_RELEASE = 3'd3,
        PH_ENDED   = 3'd4,
        PH_IDLE    = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PHASE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LEVEL,
        ST_SCALE,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

/* rtl/adhsr_regs.sv */
// apb configuration registers for the adhsr envelope
`default_nettype none
module adhsr_regs
    import adhsr_pkg::*;
#(
    parameter int TIME_BITS = 32,
    localparam int DATA_W   = (TIME_BITS > 32) ? 64 : 32,
    localparam int ADDR_W   = (TIME_BITS > 32) ? 6 : 5,
    localparam int IDX_LSB  = (TIME_BITS > 32) ? 3 : 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic      [TIME_BITS-1:0] attack_ticks,
    output logic      [TIME_BITS-1:0] decay_ticks,
    output logic      [TIME_BITS-1:0] hold_ticks,
    output logic      [TIME_BITS-1:0] release_ticks,
    output logic      [LVL_W-1:0]     sus_level,
    output logic      [1:0]           end_mode
);

    logic [TIME_BITS-1:0] attack_reg;
    logic [TIME_BITS-1:0] decay_reg;
    logic [TIME_BITS-1:0] hold_reg;
    logic [TIME_BITS-1:0] rel_reg;
    logic [LVL_W-1:0]     sustain_reg;
    logic [1:0]           mode_reg;
    logic [2:0]           idx;
    logic                 wr_en;

    assign idx   = paddr[ADDR_W-1:IDX_LSB];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            hold_reg    <= '0;
            rel_reg     <= '0;
            sustain_reg <= ONE_Q15;
            mode_reg    <= END_STOP;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ATTACK:  attack_reg  <= pwdata[TIME_BITS-1:0];
                REG_DECAY:   decay_reg   <= pwdata[TIME_BITS-1:0];
                REG_HOLD:    hold_reg    <= pwdata[TIME_BITS-1:0];
                REG_RELEASE: rel_reg     <= pwdata[TIME_BITS-1:0];
                REG_SUSTAIN: sustain_reg <= pwdata[LVL_W-1:0];
                REG_ENDMODE: mode_reg    <= pwdata[1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ATTACK:  prdata = DATA_W'(attack_reg);
            REG_DECAY:   prdata = DATA_W'(decay_reg);
            REG_HOLD:    prdata = DATA_W'(hold_reg);
            REG_RELEASE: prdata = DATA_W'(rel_reg);
            REG_SUSTAIN: prdata = DATA_W'(sustain_reg);
            REG_ENDMODE: prdata = DATA_W'(mode_reg);
            default:     prdata = '0;
        endcase
    end

    assign attack_ticks  = attack_reg;
    assign decay_ticks   = decay_reg;
    assign hold_ticks    = hold_reg;
    assign release_ticks = rel_reg;
    assign sus_level     = sustain_reg;
    assign end_mode      = mode_reg;

endmodule
`default_nettype wire

/* rtl/adhsr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module adhsr_div
    import adhsr_pkg::*;
#(
    parameter int TIME_BITS = 32,
    localparam int NUM_W    = TIME_BITS + QUOT_W,
    localparam int CNT_W    = $clog2(QUOT_W + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_W-1:0]     num,
    input  wire logic [TIME_BITS-1:0] den,
    output logic                      done,
    output logic      [QUOT_W-1:0]    quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] den_reg, den_next;
    logic [QUOT_W-1:0]    lo_reg, lo_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic                 ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
    end

    // quotient fits in QUOT_W bits, so the top of the numerator starts below den
    assign trial = {rem_reg, lo_reg[QUOT_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = num[NUM_W-1:QUOT_W];
            lo_next   = num[QUOT_W-1:0];
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            lo_next   = {lo_reg[QUOT_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

/* rtl/linear_adhsr_envelope.sv */
// linear attack/decay/hold/release envelope applied to a sample stream
// reset or all-zero item: start, scale and finish states; other items add segment steps,
// then a multiply and a serial divide unless hold or the end is reached; finish waits while
// the output is stalled; next item is taken the cycle after the result is registered
// async active-low reset: offset and finished flag cleared, durations zero,
// sustain 1.0, stop mode
`default_nettype none
module linear_adhsr_envelope
    import adhsr_pkg::*;
#(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int DATA_W     = (TIME_BITS > 32) ? 64 : 32,
    localparam int ADDR_W     = (TIME_BITS > 32) ? 6 : 5,
    localparam int IN_W       = ((TIME_BITS + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + LVL_W + 4 + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // tick_time, sample_in
    input  wire logic [0:0]        s_axis_tuser,   // operation
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_W-1:0]  m_axis_tdata,   // sample_out, level, phase, finished
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int MA_W   = ((TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS) + 1;
    localparam int PROD_W = MA_W + FACT_W;
    localparam int BND_W  = TIME_BITS + 2;

    logic [TIME_BITS-1:0] attack_ticks;
    logic [TIME_BITS-1:0] decay_ticks;
    logic [TIME_BITS-1:0] hold_ticks;
    logic [TIME_BITS-1:0] release_ticks;
    logic [LVL_W-1:0]     sus_level;
    logic [1:0]           end_mode;
    logic [LVL_W-1:0]     sus_sat;

    state_t                   state_reg, state_next;
    phase_t                   ph_reg, ph_next;
    logic                     op_reg, op_next;
    logic [TIME_BITS-1:0]     now_reg, now_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [TIME_BITS-1:0]     offset_reg, offset_next;
    logic                     fin_reg, fin_next;
    logic [TIME_BITS-1:0]     t_reg, t_next;
    logic [BND_W-1:0]         base_reg, base_next;
    logic [BND_W-1:0]         bound_reg, bound_next;
    logic [LVL_W-1:0]         lvl_reg, lvl_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]   out_sample_reg, out_sample_next;
    logic [LVL_W-1:0]         out_level_reg, out_level_next;
    phase_t                   out_phase_reg, out_phase_next;
    logic                     out_fin_reg, out_fin_next;

    logic                     div_start;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [TIME_BITS-1:0]     dur_cur;
    logic [TIME_BITS-1:0]     dur_after;
    phase_t                   ph_after;
    logic [LVL_W-1:0]         factor;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [FACT_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     all_zero;

    adhsr_regs #(.TIME_BITS(TIME_BITS)) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .attack_ticks  (attack_ticks),
        .decay_ticks   (decay_ticks),
        .hold_ticks    (hold_ticks),
        .release_ticks (release_ticks),
        .sus_level     (sus_level),
        .end_mode      (end_mode)
    );

    adhsr_div #(.TIME_BITS(TIME_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg[TIME_BITS+QUOT_W-1:0]),
        .den   (dur_cur),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign pready   = 1'b1;
    assign sus_sat  = (sus_level > ONE_Q15) ? ONE_Q15 : sus_level;
    assign all_zero = ((attack_ticks | decay_ticks | hold_ticks | release_ticks) == '0);

    always_comb
    begin
        case (ph_reg)
            PH_ATTACK:
            begin
                dur_cur   = attack_ticks;
                dur_after = decay_ticks;
                ph_after  = PH_DECAY;
                factor    = ONE_Q15;
            end
            PH_DECAY:
            begin
                dur_cur   = decay_ticks;
                dur_after = hold_ticks;
                ph_after  = PH_HOLD;
                factor    = ONE_Q15 - sus_sat;
            end
            PH_HOLD:
            begin
                dur_cur   = hold_ticks;
                dur_after = release_ticks;
                ph_after  = PH_RELEASE;
                factor    = sus_sat;
            end
            default:
            begin
                dur_cur   = release_ticks;
                dur_after = release_ticks;
                ph_after  = PH_ENDED;
                factor    = sus_sat;
            end
        endcase
    end

    // shared multiplier: segment product, then sample scaling
    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = MA_W'(sample_reg);
            mul_b = FACT_W'(lvl_reg);
        end
        else
        begin
            mul_a = MA_W'(t_reg);
            mul_b = FACT_W'(factor);
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg         <= ph_next;
        op_reg         <= op_next;
        now_reg        <= now_next;
        sample_reg     <= sample_next;
        t_reg          <= t_next;
        base_reg       <= base_next;
        bound_reg      <= bound_next;
        lvl_reg        <= lvl_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        out_level_reg  <= out_level_next;
        out_phase_reg  <= out_phase_next;
        out_fin_reg    <= out_fin_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        sample_next     = sample_reg;
        offset_next     = offset_reg;
        fin_next        = fin_reg;
        t_next          = t_reg;
        base_next       = base_reg;
        bound_next      = bound_reg;
        lvl_next        = lvl_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sample_next = out_sample_reg;
        out_level_next  = out_level_reg;
        out_phase_next  = out_phase_reg;
        out_fin_next    = out_fin_reg;
        div_start       = 1'b0;
        s_axis_tready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser[0];
                    now_next    = s_axis_tdata[TIME_BITS-1:0];
                    sample_next = s_axis_tdata[TIME_BITS +: SAMPLE_BITS];
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (op_reg == OP_RESET)
                begin
                    offset_next = '0;
                    fin_next    = 1'b0;
                    lvl_next    = '0;
                    ph_next     = PH_IDLE;
                    state_next  = ST_SCALE;
                end
                else if (all_zero)
                begin
                    lvl_next   = '0;
                    ph_next    = PH_IDLE;
                    state_next = ST_SCALE;
                end
                else
                begin
                    t_next     = (now_reg >= offset_reg) ? now_reg - offset_reg : '0;
                    base_next  = '0;
                    bound_next = BND_W'(attack_ticks);
                    ph_next    = PH_ATTACK;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (BND_W'(t_reg) < bound_reg)
                begin
                    // elapsed time within the current segment
                    t_next = t_reg - base_reg[TIME_BITS-1:0];
                    if (ph_reg == PH_HOLD)
                    begin
                        lvl_next   = sus_sat;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else if (ph_reg == PH_RELEASE)
                begin
                    if (end_mode == END_RESTART)
                    begin
                        offset_next = now_reg;
                        t_next      = '0;
                        base_next   = '0;
                        bound_next  = BND_W'(attack_ticks);
                        ph_next     = PH_ATTACK;
                    end
                    else
                    begin
                        if (end_mode == END_STOP)
                        begin
                            fin_next = 1'b1;
                        end
                        lvl_next   = '0;
                        ph_next    = PH_ENDED;
                        state_next = ST_SCALE;
                    end
                end
                else
                begin
                    base_next  = bound_reg;
                    bound_next = bound_reg + BND_W'(dur_after);
                    ph_next    = ph_after;
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                case (ph_reg)
                    PH_ATTACK: lvl_next = div_quot;
                    PH_DECAY:  lvl_next = ONE_Q15 - div_quot;
                    default:   lvl_next = sus_sat - div_quot;
                endcase
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                prod_next  = mul_p;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    // arithmetic shift by 15 gives floor rounding
                    out_sample_next = prod_reg[15 +: SAMPLE_BITS];
                    out_level_next  = lvl_reg;
                    out_phase_next  = ph_reg;
                    out_fin_next    = fin_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_fin_reg, out_phase_reg, out_level_reg, out_sample_reg});

endmodule
`default_nettype wire

/* rtl/adhsr_chk.sv */
// port-level checks for the adhsr envelope, bound to the top level
`default_nettype none
`include "linear_adhsr_envelope_defines.svh"
module adhsr_chk
    import adhsr_pkg::*;
#(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int OUT_W      = ((SAMPLE_BITS + LVL_W + 4 + 7) / 8) * 8
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    logic [SAMPLE_BITS-1:0] smp_f;
    logic [LVL_W-1:0]       lvl_f;
    logic [2:0]             ph_f;

    assign smp_f = m_axis_tdata[SAMPLE_BITS-1:0];
    assign lvl_f = m_axis_tdata[SAMPLE_BITS +: LVL_W];
    assign ph_f  = m_axis_tdata[SAMPLE_BITS + LVL_W +: 3];

    `ADHSR_ASSERT_IMP(a_level_range, m_axis_tvalid, lvl_f <= ONE_Q15)
    `ADHSR_ASSERT_IMP(a_end_level_zero, m_axis_tvalid && (ph_f == PH_ENDED || ph_f == PH_IDLE), lvl_f == '0)
    `ADHSR_ASSERT_IMP(a_zero_level_zero_out, m_axis_tvalid && lvl_f == '0, smp_f == '0)
    `ADHSR_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ADHSR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind linear_adhsr_envelope adhsr_chk #(
    .TIME_BITS   (TIME_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_adhsr_chk (.*);
`default_nettype wire
